// ===== src/fpel_pkg.sv =====
// Shared constants, item type and constant-divide helpers for the exp/ln unit.
package fpel_pkg;

  localparam int BISECTION_STEPS = 30;
  localparam int CELL_STAGES     = 7;
  localparam int ARG_W           = 32;
  localparam int BND_W           = 15;
  localparam int EV_W            = 16;
  localparam int RES_W           = 17;

  localparam logic signed [BND_W-1:0] SEARCH_LO   = -15'sd3000;
  localparam logic signed [BND_W-1:0] SEARCH_HI   = 15'sd12000;
  localparam logic signed [ARG_W-1:0] EXP_TOP_IN  = 32'sd4000;
  localparam logic signed [ARG_W-1:0] ONE_ARG     = 32'sd1000;
  localparam logic [EV_W-1:0]         EXP_TOP_OUT = 16'd54598;
  localparam logic [EV_W-1:0]         ONE_FX      = 16'd1000;
  localparam logic signed [RES_W-1:0] LN_BAD      = -17'sd10000;
  localparam logic signed [RES_W-1:0] LN_ONE      = 17'sd0;

  localparam logic OP_EXP = 1'b0;
  localparam logic OP_LN  = 1'b1;

  // Reciprocals: ceil(2^s / d), exact over the value ranges used here
  localparam logic [28:0] DIV1000_M = 29'd274877907;  // s = 38
  localparam logic [17:0] DIV6_M    = 18'd174763;     // s = 20
  localparam logic [19:0] DIV24_M   = 20'd699051;     // s = 24

  typedef enum logic [1:0] {
    EXP_ONE,
    EXP_TOP,
    EXP_SERIES
  } exp_kind_t;

  typedef struct packed {
    logic                    op;
    logic signed [ARG_W-1:0] arg;
    logic signed [BND_W-1:0] lo;
    logic signed [BND_W-1:0] hi;
    logic [EV_W-1:0]         res;
  } item_t;

  function automatic logic [18:0] div1000(input logic [27:0] x);
    logic [56:0] prod;
    prod = {29'b0, x} * {28'b0, DIV1000_M};
    return prod[56:38];
  endfunction

  function automatic logic [13:0] div6(input logic [15:0] x);
    logic [35:0] prod;
    prod = {18'b0, x} * {18'b0, DIV6_M};
    return prod[33:20];
  endfunction

  function automatic logic [13:0] div24(input logic [17:0] x);
    logic [37:0] prod;
    prod = {20'b0, x} * {18'b0, DIV24_M};
    return prod[37:24];
  endfunction

  // (lo + hi) / 2, truncated toward zero
  function automatic logic signed [BND_W-1:0] midpoint(input logic signed [BND_W-1:0] lo,
                                                      input logic signed [BND_W-1:0] hi);
    logic [BND_W:0] s;
    s = {lo[BND_W-1], lo} + {hi[BND_W-1], hi};
    s = s + {{BND_W{1'b0}}, s[BND_W]};
    return s[BND_W:1];
  endfunction

endpackage

// ===== src/fpel_cell.sv =====
// One bisection cell: seven-rank pipeline, an exp evaluation followed by a bound update.
module fpel_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  fpel_pkg::item_t in_item,
  output logic            out_valid,
  output fpel_pkg::item_t out_item
);

  logic signed [fpel_pkg::BND_W-1:0] mid_in;
  logic signed [fpel_pkg::ARG_W-1:0] x_arg;
  fpel_pkg::exp_kind_t               kind_c;
  logic [11:0]                       x_c;

  logic [5:0]          v;
  fpel_pkg::item_t     it1, it2, it3, it4, it5, it6;
  fpel_pkg::exp_kind_t k1, k2, k3, k4, k5, k6;
  logic [11:0]         x1, x2, x3, x4, x5, x6;
  logic [23:0]         m2_1;
  logic [13:0]         p2_2, p2_3, p2_4, p2_5, p2_6;
  logic [25:0]         m3_3;
  logic [15:0]         p3_4;
  logic [27:0]         m4_5;
  logic [13:0]         t3_5, t3_6;
  logic [17:0]         p4_6;

  logic [18:0] q2, q3, q4;
  logic [13:0] t4;
  logic [fpel_pkg::EV_W-1:0] sum, ev;
  logic signed [fpel_pkg::BND_W-1:0] mid6;
  logic go_up;
  fpel_pkg::item_t out_next;

  always_comb begin
    mid_in = fpel_pkg::midpoint(in_item.lo, in_item.hi);
    x_arg  = (in_item.op == fpel_pkg::OP_LN) ?
             {{(fpel_pkg::ARG_W-fpel_pkg::BND_W){mid_in[fpel_pkg::BND_W-1]}}, mid_in} :
             in_item.arg;
    if (x_arg <= 0) begin
      kind_c = fpel_pkg::EXP_ONE;
    end else if (x_arg > fpel_pkg::EXP_TOP_IN) begin
      kind_c = fpel_pkg::EXP_TOP;
    end else begin
      kind_c = fpel_pkg::EXP_SERIES;
    end
    x_c = (kind_c == fpel_pkg::EXP_SERIES) ? x_arg[11:0] : 12'd0;
  end

  assign q2 = fpel_pkg::div1000({4'b0, m2_1});
  assign q3 = fpel_pkg::div1000({2'b0, m3_3});
  assign q4 = fpel_pkg::div1000(m4_5);

  always_comb begin
    t4   = fpel_pkg::div24(p4_6);
    sum  = fpel_pkg::ONE_FX + {4'b0, x6} + {3'b0, p2_6[13:1]} + {2'b0, t3_6} + {2'b0, t4};
    case (k6)
      fpel_pkg::EXP_ONE:    ev = fpel_pkg::ONE_FX;
      fpel_pkg::EXP_TOP:    ev = fpel_pkg::EXP_TOP_OUT;
      fpel_pkg::EXP_SERIES: ev = sum;
      default:              ev = fpel_pkg::ONE_FX;
    endcase
    mid6  = fpel_pkg::midpoint(it6.lo, it6.hi);
    go_up = $signed({17'b0, ev}) < $signed({it6.arg[fpel_pkg::ARG_W-1], it6.arg});
    out_next = it6;
    if (it6.op == fpel_pkg::OP_LN) begin
      if (go_up) begin
        out_next.lo = mid6;
      end else begin
        out_next.hi = mid6;
      end
    end else begin
      out_next.res = ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[4:0], in_valid};
      out_valid <= v[5];
    end
    if (en) begin
      it1 <= in_item; k1 <= kind_c; x1 <= x_c;
      m2_1 <= {12'b0, x_c} * {12'b0, x_c};

      it2 <= it1; k2 <= k1; x2 <= x1;
      p2_2 <= q2[13:0];

      it3 <= it2; k3 <= k2; x3 <= x2; p2_3 <= p2_2;
      m3_3 <= {12'b0, p2_2} * {14'b0, x2};

      it4 <= it3; k4 <= k3; x4 <= x3; p2_4 <= p2_3;
      p3_4 <= q3[15:0];

      it5 <= it4; k5 <= k4; x5 <= x4; p2_5 <= p2_4;
      m4_5 <= {12'b0, p3_4} * {16'b0, x4};
      t3_5 <= fpel_pkg::div6(p3_4);

      it6 <= it5; k6 <= k5; x6 <= x5; p2_6 <= p2_5; t3_6 <= t3_5;
      p4_6 <= q4[17:0];

      out_item <= out_next;
    end
  end

  // The bracket never inverts
  a_bracket_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.op == fpel_pkg::OP_LN |-> out_item.lo <= out_item.hi)
    else $error("bisection bracket inverted");

  a_series_bound: assert property (@(posedge clk) disable iff (rst)
    v[5] && k6 == fpel_pkg::EXP_SERIES |-> sum <= 16'd34332)
    else $error("series sum out of range");

  a_valid_shift: assert property (@(posedge clk) disable iff (rst)
    en && v[5] |=> out_valid)
    else $error("item lost in cell");

endmodule

// ===== src/fixed_point_exp_ln_unit.sv =====
// Top level: exp/ln unit built from a chain of bisection cells.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------
//  in      | in_valid  | in_stall  | op, operand_value
//  out     | out_valid | out_stall | result_value
//
// One item enters per cycle while in_stall is low; each item passes through
// BISECTION_STEPS cells of seven ranks each, then the output register.
// Reset clears all valid bits; payload registers are not reset.
// The whole chain holds while a result waits under out_stall.
module fixed_point_exp_ln_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               op,
  input  logic signed [fpel_pkg::ARG_W-1:0]  operand_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fpel_pkg::RES_W-1:0]  result_value
);

  logic                en;
  logic                ch_valid [0:fpel_pkg::BISECTION_STEPS];
  fpel_pkg::item_t     ch_item  [0:fpel_pkg::BISECTION_STEPS];
  fpel_pkg::item_t     last;
  logic signed [fpel_pkg::BND_W-1:0] ln_mid;
  logic signed [fpel_pkg::RES_W-1:0] result_next;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign ch_valid[0] = in_valid;
  assign ch_item[0]  = '{op:  op,
                         arg: operand_value,
                         lo:  fpel_pkg::SEARCH_LO,
                         hi:  fpel_pkg::SEARCH_HI,
                         res: fpel_pkg::ONE_FX};

  for (genvar g = 0; g < fpel_pkg::BISECTION_STEPS; g++) begin : g_cell
    fpel_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (ch_valid[g]),
      .in_item  (ch_item[g]),
      .out_valid(ch_valid[g+1]),
      .out_item (ch_item[g+1])
    );
  end

  always_comb begin
    last   = ch_item[fpel_pkg::BISECTION_STEPS];
    ln_mid = fpel_pkg::midpoint(last.lo, last.hi);
    if (last.op == fpel_pkg::OP_EXP) begin
      result_next = {1'b0, last.res};
    end else if (last.arg <= 0) begin
      result_next = fpel_pkg::LN_BAD;
    end else if (last.arg == fpel_pkg::ONE_ARG) begin
      result_next = fpel_pkg::LN_ONE;
    end else begin
      result_next = {{(fpel_pkg::RES_W-fpel_pkg::BND_W){ln_mid[fpel_pkg::BND_W-1]}}, ln_mid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ch_valid[fpel_pkg::BISECTION_STEPS];
    end
    if (en) begin
      result_value <= result_next;
    end
  end

  a_stall_rule: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_value >= fpel_pkg::LN_BAD) && (result_value <= 17'sd54598))
    else $error("result out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    ch_valid[fpel_pkg::BISECTION_STEPS] && en |=> out_valid)
    else $error("item dropped at output");

endmodule
